/* sv/psc_pkg.sv */
// Shared widths, shift amounts, register indexes and types for the pressure compensation block.
package psc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int DIFF_W    = RAW_W + 1;
  localparam int PROD_W    = DIFF_W + CAL_W + 1;
  localparam int TEMP_W    = 19;
  localparam int PRESS_W   = 23;
  localparam int COEF_W    = 36;
  localparam int LO_W      = 18;
  localparam int HI_W      = COEF_W - LO_W;
  localparam int PPLO_W    = RAW_W + LO_W;
  localparam int PPHI_W    = RAW_W + 1 + HI_W;
  localparam int SUM_W     = 61;
  localparam int DVAL_W    = 41;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG      = 7;

  localparam int REF_SHIFT       = 8;
  localparam int TEMP_SHIFT      = 23;
  localparam int OFF_DIV_SHIFT   = 6;
  localparam int SENS_DIV_SHIFT  = 7;
  localparam int OFF_BASE_SHIFT  = 17;
  localparam int SENS_BASE_SHIFT = 16;
  localparam int PRESS_SHIFT_A   = 21;
  localparam int PRESS_SHIFT_B   = 15;
  localparam int TEMP_BASE       = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BASE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE      = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] off_base;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] off_temp_coeff;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_slope;
  } cal_t;

endpackage

/* sv/psc_ctrl.sv */
// Valid bits and per-stage load enables for the compensation pipeline.
module psc_ctrl
  import psc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output logic [NSTG-1:0] en
);

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  // A stage may load when it is empty or when its contents move on this cycle.
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign en        = rdy;
  assign in_stall  = !rdy[0];
  assign out_valid = vld[NSTG-1];

endmodule

/* sv/psc_coef.sv */
// Front stages: temperature difference, three coefficient products, temperature, offset and sensitivity.
module psc_coef
  import psc_pkg::*;
(
  input  logic                     clk,
  input  logic [2:0]               en,
  input  cal_t                     cal,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temp,
  output logic [RAW_W-1:0]         rp,
  output logic                     nz,
  output logic signed [TEMP_W-1:0] temp,
  output logic signed [COEF_W-1:0] offset,
  output logic signed [COEF_W-1:0] sens
);

  logic [RAW_W-1:0]         rp0, rp1;
  logic                     nz0, nz1;
  logic signed [DIFF_W-1:0] diff0;
  logic signed [PROD_W-1:0] prod_t, prod_o, prod_s;
  logic signed [PROD_W-1:0] adj_t, adj_o, adj_s;
  logic signed [PROD_W-1:0] quo_t, quo_o, quo_s;
  logic signed [PROD_W-1:0] temp_sum;
  logic signed [COEF_W-1:0] off_hi, sens_hi;

  // Stage 0: difference between the raw temperature and the scaled reference.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rp0   <= raw_pressure;
      nz0   <= (|raw_pressure) && (|raw_temp);
      diff0 <= $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ref_temp, {REF_SHIFT{1'b0}}});
    end
  end

  // Stage 1: the three products of the difference with the coefficients.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rp1    <= rp0;
      nz1    <= nz0;
      prod_t <= diff0 * $signed({1'b0, cal.temp_slope});
      prod_o <= diff0 * $signed({1'b0, cal.off_temp_coeff});
      prod_s <= diff0 * $signed({1'b0, cal.sens_temp_coeff});
    end
  end

  // Division by a power of two that rounds toward zero: negative values get a bias first.
  assign adj_t = prod_t + (prod_t[PROD_W-1] ?
                 $signed({{(PROD_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{1'b1}}}) : '0);
  assign adj_o = prod_o + (prod_o[PROD_W-1] ?
                 $signed({{(PROD_W-OFF_DIV_SHIFT){1'b0}}, {OFF_DIV_SHIFT{1'b1}}}) : '0);
  assign adj_s = prod_s + (prod_s[PROD_W-1] ?
                 $signed({{(PROD_W-SENS_DIV_SHIFT){1'b0}}, {SENS_DIV_SHIFT{1'b1}}}) : '0);
  assign quo_t = adj_t >>> TEMP_SHIFT;
  assign quo_o = adj_o >>> OFF_DIV_SHIFT;
  assign quo_s = adj_s >>> SENS_DIV_SHIFT;

  assign temp_sum = quo_t + PROD_W'(TEMP_BASE);
  assign off_hi   = $signed(COEF_W'({cal.off_base, {OFF_BASE_SHIFT{1'b0}}}));
  assign sens_hi  = $signed(COEF_W'({cal.sens_base, {SENS_BASE_SHIFT{1'b0}}}));

  // Stage 2: temperature, offset and sensitivity.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rp     <= rp1;
      nz     <= nz1;
      temp   <= temp_sum[TEMP_W-1:0];
      offset <= off_hi + quo_o[COEF_W-1:0];
      sens   <= sens_hi + quo_s[COEF_W-1:0];
    end
  end

endmodule

/* sv/psc_press.sv */
// Back stages: raw pressure times sensitivity in two partial products, scaling and offset removal.
module psc_press
  import psc_pkg::*;
(
  input  logic                     clk,
  input  logic [2:0]               en,
  input  logic [RAW_W-1:0]         rp,
  input  logic signed [COEF_W-1:0] sens,
  input  logic signed [COEF_W-1:0] offset,
  output logic signed [DVAL_W-1:0] dval
);

  logic [PPLO_W-1:0]        pp_lo;
  logic signed [PPHI_W-1:0] pp_hi;
  logic signed [COEF_W-1:0] offset3, offset4;
  logic signed [SUM_W-1:0]  sum4;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [SUM_W-1:0]  sum_quo;

  // Stage 3: the sensitivity is split into an unsigned low half and a signed high half.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_lo   <= rp * sens[LO_W-1:0];
      pp_hi   <= $signed({1'b0, rp}) * $signed(sens[COEF_W-1:LO_W]);
      offset3 <= offset;
    end
  end

  // Stage 4: recombine the partial products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum4    <= (SUM_W'(pp_hi) <<< LO_W) + $signed(SUM_W'(pp_lo));
      offset4 <= offset3;
    end
  end

  assign sum_adj = sum4 + (sum4[SUM_W-1] ?
                   $signed({{(SUM_W-PRESS_SHIFT_A){1'b0}}, {PRESS_SHIFT_A{1'b1}}}) : '0);
  assign sum_quo = sum_adj >>> PRESS_SHIFT_A;

  // Stage 5: scaled product minus offset.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dval <= sum_quo[DVAL_W-1:0] - DVAL_W'(offset4);
    end
  end

endmodule

/* sv/pressure_sensor_compensation.sv */
// Top level of the barometric sensor first-order compensation pipeline.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     raw_pressure, raw_temp
//   out       output     out_valid / out_stall   temp_centi, pressure_comp, result_valid
//   cfg       input      cfg_we                  cfg_index, cfg_data
//
// Seven register stages; one item can enter every cycle while in_stall is low,
// the rate being set by the single-issue pipeline.
// Reset clears the valid bits and the six calibration registers.
// A stall on the output holds the last stage; earlier stages keep filling empty slots,
// so the input stalls only once every stage holds an item.
module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RAW_W-1:0]          raw_pressure,
  input  logic [RAW_W-1:0]          raw_temp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TEMP_W-1:0]  temp_centi,
  output logic signed [PRESS_W-1:0] pressure_comp,
  output logic                      result_valid,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CAL_W-1:0]          cfg_data
);

  cal_t                     cal;
  logic [NSTG-1:0]          en;
  logic [RAW_W-1:0]         rp2;
  logic                     nz2;
  logic signed [TEMP_W-1:0] temp2;
  logic signed [COEF_W-1:0] offset2, sens2;
  logic signed [DVAL_W-1:0] dval5;
  logic signed [DVAL_W-1:0] dval_adj;
  logic signed [DVAL_W-1:0] dval_quo;
  logic signed [TEMP_W-1:0] temp_d [3];
  logic                     nz_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS_BASE:       cal.sens_base       <= cfg_data;
        REG_OFF_BASE:        cal.off_base        <= cfg_data;
        REG_SENS_TEMP_COEFF: cal.sens_temp_coeff <= cfg_data;
        REG_OFF_TEMP_COEFF:  cal.off_temp_coeff  <= cfg_data;
        REG_REF_TEMP:        cal.ref_temp        <= cfg_data;
        REG_TEMP_SLOPE:      cal.temp_slope      <= cfg_data;
        default: ;
      endcase
    end
  end

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  psc_coef u_coef (
    .clk          (clk),
    .en           (en[2:0]),
    .cal          (cal),
    .raw_pressure (raw_pressure),
    .raw_temp     (raw_temp),
    .rp           (rp2),
    .nz           (nz2),
    .temp         (temp2),
    .offset       (offset2),
    .sens         (sens2)
  );

  psc_press u_press (
    .clk    (clk),
    .en     (en[5:3]),
    .rp     (rp2),
    .sens   (sens2),
    .offset (offset2),
    .dval   (dval5)
  );

  // Temperature and the zero flag ride alongside the pressure stages.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      temp_d[0] <= temp2;
      nz_d[0]   <= nz2;
    end
    if (en[4]) begin
      temp_d[1] <= temp_d[0];
      nz_d[1]   <= nz_d[0];
    end
    if (en[5]) begin
      temp_d[2] <= temp_d[1];
      nz_d[2]   <= nz_d[1];
    end
  end

  assign dval_adj = dval5 + (dval5[DVAL_W-1] ?
                    $signed({{(DVAL_W-PRESS_SHIFT_B){1'b0}}, {PRESS_SHIFT_B{1'b1}}}) : '0);
  assign dval_quo = dval_adj >>> PRESS_SHIFT_B;

  // Output stage: a zero raw reading forces zero outputs and clears the flag.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      result_valid  <= nz_d[2];
      temp_centi    <= nz_d[2] ? temp_d[2] : '0;
      pressure_comp <= nz_d[2] ? dval_quo[PRESS_W-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_valid) |-> (temp_centi == '0 && pressure_comp == '0))
    else $error("flagged result carries nonzero outputs");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the pressure compensation pipeline, with its own arithmetic model.
`timescale 1ns / 100ps

module tb_top;
  import psc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  localparam logic [1:0] CAL_RESET   = 2'd0;
  localparam logic [1:0] CAL_MAX     = 2'd1;
  localparam logic [1:0] CAL_TYPICAL = 2'd2;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_centi;
    logic [PRESS_W-1:0] pressure_comp;
    logic               result_valid;
  } reading_t;

  typedef struct packed {
    logic [1:0]       cal_sel;
    logic [RAW_W-1:0] rp;
    logic [RAW_W-1:0] rt;
    logic             lit;
    reading_t         want;
  } probe_t;

  localparam reading_t NO_READING = '{19'd0, 23'd0, 1'b0};
  localparam reading_t AT_RESET   = '{19'd2000, 23'd0, 1'b1};
  localparam reading_t UNTYPED    = '0;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [RAW_W-1:0]          raw_pressure = '0;
  logic [RAW_W-1:0]          raw_temp = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TEMP_W-1:0]  temp_centi;
  logic signed [PRESS_W-1:0] pressure_comp;
  logic                      result_valid;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CAL_W-1:0]          cfg_data = '0;

  cal_t     cal = '0;
  reading_t due_readings[$];
  reading_t want;
  int       mismatches = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       stall_left = 0;

  cal_t cal_sets [0:2] = '{
    '0,
    '1,
    '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165}
  };

  // Rows on the reset calibration and zero-raw rows carry their result; the rest go
  // through the model.
  probe_t probes [0:20] = '{
    '{CAL_RESET,   24'hFFFFFF, 24'hFFFFFF, 1'b1, AT_RESET},
    '{CAL_RESET,   24'h000001, 24'h000001, 1'b1, AT_RESET},
    '{CAL_RESET,   24'h800000, 24'h000001, 1'b1, AT_RESET},
    '{CAL_RESET,   24'h000000, 24'h123456, 1'b1, NO_READING},
    '{CAL_RESET,   24'h654321, 24'h000000, 1'b1, NO_READING},
    '{CAL_RESET,   24'h000000, 24'h000000, 1'b1, NO_READING},
    '{CAL_MAX,     24'hFFFFFF, 24'hFFFFFF, 1'b0, UNTYPED},
    '{CAL_MAX,     24'hFFFFFF, 24'h000001, 1'b0, UNTYPED},
    '{CAL_MAX,     24'h000001, 24'h000001, 1'b0, UNTYPED},
    '{CAL_MAX,     24'h000001, 24'hFFFFFF, 1'b0, UNTYPED},
    '{CAL_MAX,     24'hFFFFFF, 24'hFFFF00, 1'b0, UNTYPED},
    '{CAL_MAX,     24'hFFFFFF, 24'hFFFEFF, 1'b0, UNTYPED},
    '{CAL_MAX,     24'h000000, 24'hFFFFFF, 1'b1, NO_READING},
    '{CAL_MAX,     24'hAAAAAA, 24'h555555, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'h8A3C51, 24'h7B4100, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'h8A3C51, 24'h7B40FF, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'h8A3C51, 24'h7B4101, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'h555555, 24'hAAAAAA, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'hFFFFFF, 24'h000001, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'h000001, 24'hFFFFFF, 1'b0, UNTYPED},
    '{CAL_TYPICAL, 24'hFFFFFF, 24'h000000, 1'b1, NO_READING}
  };

  pressure_sensor_compensation dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_pressure  (raw_pressure),
    .raw_temp      (raw_temp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .temp_centi    (temp_centi),
    .pressure_comp (pressure_comp),
    .result_valid  (result_valid),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer divisions on signed operands truncate toward zero, as the block requires.
  function automatic reading_t compensate(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt,
                                          cal_t c);
    longint dt, tc, off, sen, pr;
    reading_t r;
    r = '0;
    if (rp == '0 || rt == '0) return r;
    dt = longint'({40'd0, rt}) - (longint'({48'd0, c.ref_temp}) << REF_SHIFT);
    tc = TEMP_BASE + dt * longint'({48'd0, c.temp_slope}) / (longint'(1) << TEMP_SHIFT);
    off = (longint'({48'd0, c.off_base}) << OFF_BASE_SHIFT)
        + longint'({48'd0, c.off_temp_coeff}) * dt / (longint'(1) << OFF_DIV_SHIFT);
    sen = (longint'({48'd0, c.sens_base}) << SENS_BASE_SHIFT)
        + longint'({48'd0, c.sens_temp_coeff}) * dt / (longint'(1) << SENS_DIV_SHIFT);
    pr = (longint'({40'd0, rp}) * sen / (longint'(1) << PRESS_SHIFT_A) - off)
       / (longint'(1) << PRESS_SHIFT_B);
    r.temp_centi    = tc[TEMP_W-1:0];
    r.pressure_comp = pr[PRESS_W-1:0];
    r.result_valid  = 1'b1;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SENS_BASE:       cal.sens_base = val;
      REG_OFF_BASE:        cal.off_base = val;
      REG_SENS_TEMP_COEFF: cal.sens_temp_coeff = val;
      REG_OFF_TEMP_COEFF:  cal.off_temp_coeff = val;
      REG_REF_TEMP:        cal.ref_temp = val;
      REG_TEMP_SLOPE:      cal.temp_slope = val;
      default: ;
    endcase
  endtask

  // Writes to the two spare indexes must leave the calibration untouched.
  task automatic load_cal(input cal_t c);
    write_reg(REG_UNUSED_A, CAL_W'($urandom));
    write_reg(REG_SENS_BASE, c.sens_base);
    write_reg(REG_OFF_BASE, c.off_base);
    write_reg(REG_SENS_TEMP_COEFF, c.sens_temp_coeff);
    write_reg(REG_OFF_TEMP_COEFF, c.off_temp_coeff);
    write_reg(REG_REF_TEMP, c.ref_temp);
    write_reg(REG_TEMP_SLOPE, c.temp_slope);
    write_reg(REG_UNUSED_B, CAL_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (due_readings.size() != 0) @(posedge clk);
  endtask

  task automatic feed(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
                      input logic lit, input reading_t typed);
    in_valid     <= 1'b1;
    raw_pressure <= rp;
    raw_temp     <= rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_readings.push_back(lit ? typed : compensate(rp, rt, cal));
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_readings.size() == 0) begin
        $error("result transfer with no reading outstanding");
        mismatches++;
      end else begin
        want = due_readings.pop_front();
        if (temp_centi !== want.temp_centi) begin
          $error("temp_centi: expected %0d, got %0d", $signed(want.temp_centi), temp_centi);
          mismatches++;
        end
        if (pressure_comp !== want.pressure_comp) begin
          $error("pressure_comp: expected %0d, got %0d", $signed(want.pressure_comp),
                 pressure_comp);
          mismatches++;
        end
        if (result_valid !== want.result_valid) begin
          $error("result_valid: expected %0d, got %0d", want.result_valid, result_valid);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [1:0]       cur_sel;
    cal_t             next_cal;
    logic [RAW_W-1:0] rp, rt;
    int unsigned      k;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 30;
    stall_pct = 20;
    cur_sel   = CAL_RESET;
    foreach (probes[i]) begin
      if (probes[i].cal_sel != cur_sel) begin
        in_valid <= 1'b0;
        wait_idle();
        load_cal(cal_sets[probes[i].cal_sel]);
        cur_sel = probes[i].cal_sel;
      end
      feed(probes[i].rp, probes[i].rt, probes[i].lit, probes[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (ph)
        0:       next_cal = '0;
        1:       next_cal = '1;
        3:       next_cal = cal_sets[CAL_TYPICAL];
        default: next_cal = {$urandom, $urandom, $urandom};
      endcase
      load_cal(next_cal);
      for (int n = 0; n < 305; n++) begin
        if (n % 50 == 0) begin
          // The last phase runs at full rate on both sides.
          k = (ph == 5) ? 0 : $urandom_range(0, 2);
          gap_pct   = (k == 0) ? 0 : (k == 1) ? 15 : 50;
          stall_pct = (k == 0) ? 0 : (k == 1) ? 15 : 40;
        end
        if (ph == 2 && n == 150) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_idle();
        end
        k  = $urandom_range(0, 39);
        rp = (k == 0) ? '0 : (k == 1) ? '1 : RAW_W'($urandom);
        k  = $urandom_range(0, 39);
        // Many temperatures sit near the reference so the difference changes sign often.
        if (k == 0)
          rt = '0;
        else if (k == 1)
          rt = '1;
        else if (k < 20)
          rt = {cal.ref_temp, 8'd0} + RAW_W'($urandom_range(0, 8191)) - RAW_W'(4096);
        else
          rt = RAW_W'($urandom);
        feed(rp, rt, 1'b0, UNTYPED);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
